// ===== src/vmd_pkg.sv =====
// ============================================================================
// vmd_pkg
// Shared types and constants for the 2x2x2 voxel mode downsampler.
// ============================================================================
package vmd_pkg;

    localparam int NUM_SAMPLES = 8;
    localparam int ID_W        = 16;
    localparam int WEIGHT_W    = 4;
    localparam int SCORE_W     = 7;   // 4 * 15 + 4 * 1 = 64 fits in 7 bits
    localparam int COUNT_W     = 4;   // up to 8 samples
    localparam int PRIO_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int MAX_AIR     = 4;   // more air samples than this is mostly air
    localparam int TOP_BIT     = 1;   // dy bit of the sample position

    localparam logic [PRIO_W-1:0] PRIO_SAND  = 3'd4;
    localparam logic [PRIO_W-1:0] PRIO_WATER = 3'd3;
    localparam logic [PRIO_W-1:0] PRIO_DIRT  = 3'd2;
    localparam logic [PRIO_W-1:0] PRIO_STONE = 3'd1;
    localparam logic [PRIO_W-1:0] PRIO_NONE  = 3'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AIR_ID     = 3'd0,
        REG_SAND_ID    = 3'd1,
        REG_GRAVEL_ID  = 3'd2,
        REG_WATER_ID   = 3'd3,
        REG_DIRT_ID    = 3'd4,
        REG_STONE_ID   = 3'd5,
        REG_TOP_WEIGHT = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [ID_W-1:0]     air_id;
        logic [ID_W-1:0]     sand_id;
        logic [ID_W-1:0]     gravel_id;
        logic [ID_W-1:0]     water_id;
        logic [ID_W-1:0]     dirt_id;
        logic [ID_W-1:0]     stone_id;
        logic [WEIGHT_W-1:0] top_weight;
    } cfg_t;

    // Result of the compare stage.
    typedef struct packed {
        logic [NUM_SAMPLES-1:0][ID_W-1:0]        id;
        logic [NUM_SAMPLES-1:0][NUM_SAMPLES-1:0] eq;
        logic [NUM_SAMPLES-1:0]                  air;
        logic [NUM_SAMPLES-1:0][PRIO_W-1:0]      prio;
    } cmp_t;

    // Ranking key of one candidate; a larger packed value wins.
    typedef struct packed {
        logic               cand;
        logic [SCORE_W-1:0] score;
        logic [COUNT_W-1:0] count;
        logic [PRIO_W-1:0]  prio;
        logic [ID_W-1:0]    id_inv;
    } key_t;

    // Result of the score stage.
    typedef struct packed {
        key_t [NUM_SAMPLES-1:0] key;
        logic                   mostly_air;
    } score_t;

endpackage

// ===== src/vmd_compare.sv =====
// ============================================================================
// vmd_compare
// First pipeline stage: pairwise id equality, air flags and priority codes.
// ============================================================================
module vmd_compare (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  vmd_pkg::cfg_t                             cfg,
    input  logic                                      valid_in,
    output logic                                      ready_in,
    input  logic [vmd_pkg::NUM_SAMPLES-1:0][vmd_pkg::ID_W-1:0] ids,
    output logic                                      valid_out,
    input  logic                                      ready_out,
    output vmd_pkg::cmp_t                             data_out
);

    logic          valid_reg;
    vmd_pkg::cmp_t data_reg;
    vmd_pkg::cmp_t data_next;

    always_comb
    begin
        data_next.id = ids;
        for (int i = 0; i < vmd_pkg::NUM_SAMPLES; i++)
        begin
            for (int j = 0; j < vmd_pkg::NUM_SAMPLES; j++)
            begin
                data_next.eq[i][j] = (ids[i] == ids[j]);
            end
            data_next.air[i] = (ids[i] == cfg.air_id);
            if (ids[i] == cfg.sand_id || ids[i] == cfg.gravel_id)
                data_next.prio[i] = vmd_pkg::PRIO_SAND;
            else if (ids[i] == cfg.water_id)
                data_next.prio[i] = vmd_pkg::PRIO_WATER;
            else if (ids[i] == cfg.dirt_id)
                data_next.prio[i] = vmd_pkg::PRIO_DIRT;
            else if (ids[i] == cfg.stone_id)
                data_next.prio[i] = vmd_pkg::PRIO_STONE;
            else
                data_next.prio[i] = vmd_pkg::PRIO_NONE;
        end
    end

    assign ready_in = !valid_reg || ready_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready_in)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_in)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

// ===== src/vmd_score.sv =====
// ============================================================================
// vmd_score
// Second pipeline stage: weighted score, sample count and air count.
// ============================================================================
module vmd_score (
    input  logic            clk,
    input  logic            rst_n,
    input  vmd_pkg::cfg_t   cfg,
    input  logic            valid_in,
    output logic            ready_in,
    input  vmd_pkg::cmp_t   data_in,
    output logic            valid_out,
    input  logic            ready_out,
    output vmd_pkg::score_t data_out
);

    logic                            valid_reg;
    vmd_pkg::score_t                 data_reg;
    vmd_pkg::score_t                 data_next;
    logic [vmd_pkg::COUNT_W-1:0]     air_count;
    logic [vmd_pkg::SCORE_W-1:0]     score_acc;
    logic [vmd_pkg::COUNT_W-1:0]     count_acc;
    logic [vmd_pkg::SCORE_W-1:0]     weight;

    always_comb
    begin
        air_count = '0;
        score_acc = '0;
        count_acc = '0;
        weight    = '0;
        data_next = '0;
        for (int j = 0; j < vmd_pkg::NUM_SAMPLES; j++)
        begin
            air_count = air_count + vmd_pkg::COUNT_W'(data_in.air[j]);
        end
        for (int i = 0; i < vmd_pkg::NUM_SAMPLES; i++)
        begin
            score_acc = '0;
            count_acc = '0;
            for (int j = 0; j < vmd_pkg::NUM_SAMPLES; j++)
            begin
                weight = (j[vmd_pkg::TOP_BIT])
                         ? vmd_pkg::SCORE_W'(cfg.top_weight)
                         : vmd_pkg::SCORE_W'(1);
                if (data_in.eq[i][j])
                begin
                    score_acc = score_acc + weight;
                    count_acc = count_acc + vmd_pkg::COUNT_W'(1);
                end
            end
            data_next.key[i].cand   = !data_in.air[i];
            data_next.key[i].score  = score_acc;
            data_next.key[i].count  = count_acc;
            data_next.key[i].prio   = data_in.prio[i];
            data_next.key[i].id_inv = ~data_in.id[i];
        end
        data_next.mostly_air = (air_count > vmd_pkg::COUNT_W'(vmd_pkg::MAX_AIR));
    end

    assign ready_in = !valid_reg || ready_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready_in)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_in)
            data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

// ===== src/vmd_select.sv =====
// ============================================================================
// vmd_select
// Third and fourth pipeline stages: registered max tree over the ranking
// keys and the output register.
// ============================================================================
module vmd_select (
    input  logic                      clk,
    input  logic                      rst_n,
    input  vmd_pkg::cfg_t             cfg,
    input  logic                      valid_in,
    output logic                      ready_in,
    input  vmd_pkg::score_t           data_in,
    output logic                      valid_out,
    input  logic                      ready_out,
    output logic [vmd_pkg::ID_W-1:0]  chosen,
    output logic                      mostly
);

    localparam int HALF    = vmd_pkg::NUM_SAMPLES / 2;
    localparam int QUARTER = vmd_pkg::NUM_SAMPLES / 4;

    function automatic vmd_pkg::key_t key_max(input vmd_pkg::key_t a, input vmd_pkg::key_t b);
        key_max = (b > a) ? b : a;
    endfunction

    // Stage three: four pair winners.
    logic                        s3_valid_reg;
    logic                        s3_ready;
    vmd_pkg::key_t [HALF-1:0]    s3_key_reg;
    vmd_pkg::key_t [HALF-1:0]    s3_key_next;
    logic                        s3_mostly_reg;

    // Stage four: output register.
    logic                        out_valid_reg;
    logic [vmd_pkg::ID_W-1:0]    chosen_reg;
    logic [vmd_pkg::ID_W-1:0]    chosen_next;
    logic                        mostly_reg;
    logic                        cand_reg;
    vmd_pkg::key_t [QUARTER-1:0] s4_pair;
    vmd_pkg::key_t               s4_best;

    always_comb
    begin
        for (int k = 0; k < HALF; k++)
        begin
            s3_key_next[k] = key_max(data_in.key[2*k], data_in.key[2*k+1]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < QUARTER; k++)
        begin
            s4_pair[k] = key_max(s3_key_reg[2*k], s3_key_reg[2*k+1]);
        end
        s4_best = key_max(s4_pair[0], s4_pair[1]);
        // With four or fewer air samples a candidate always exists.
        if (s3_mostly_reg || !s4_best.cand)
            chosen_next = cfg.air_id;
        else
            chosen_next = ~s4_best.id_inv;
    end

    assign s3_ready = !out_valid_reg || ready_out;
    assign ready_in = !s3_valid_reg || s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_in)
                s3_valid_reg <= valid_in;
            if (s3_ready)
                out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in && ready_in)
        begin
            s3_key_reg    <= s3_key_next;
            s3_mostly_reg <= data_in.mostly_air;
        end
        if (s3_valid_reg && s3_ready)
        begin
            chosen_reg <= chosen_next;
            mostly_reg <= s3_mostly_reg;
            cand_reg   <= s4_best.cand;
        end
    end

    assign valid_out = out_valid_reg;
    assign chosen    = chosen_reg;
    assign mostly    = mostly_reg;

    // A group that moves out of stage three is in the output register next.
    a_s3_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_ready) |=> out_valid_reg)
        else $error("stage three transfer lost");

    // A group that is not mostly air always has a non-air winner.
    a_winner_exists: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !mostly_reg) |-> cand_reg)
        else $error("no candidate for a group that is not mostly air");

endmodule

// ===== src/voxel_mode_downsample_2x2x2.sv =====
// ============================================================================
// voxel_mode_downsample_2x2x2
// Weighted mode filter that reduces one 2x2x2 voxel group to one material.
// ============================================================================
// The block accepts one group of eight material ids per clock cycle while
// the output side does not stall, since every stage is fully pipelined, and
// returns one result per group, in order. An accepted group passes through
// the compare register, the score register, the stage three key register
// and the output register, where it is offered. The work is split into four
// register stages: id comparison, weighted scoring, a pairwise max over the
// ranking keys, and a final max that feeds the output register. Every stage
// carries its own valid bit, so a stall on the output side fills bubbles
// first and only then holds the input side; no group is lost or repeated.
// When more than four samples equal air_id the result is air_id with
// mostly_air set. Otherwise the non-air material with the highest weighted
// score wins, with ties broken by sample count, then semantic priority, then
// the smaller id. Configuration writes are always taken (cfg_ready is tied
// high) and must only be made while no group is in flight; writes to index
// seven are ignored.
module voxel_mode_downsample_2x2x2 (
    input  logic                              clk,
    input  logic                              rst_n,

    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vmd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vmd_pkg::ID_W-1:0]          cfg_data,

    // Input channel: one voxel group per transfer.
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [vmd_pkg::ID_W-1:0]          sample_0,
    input  logic [vmd_pkg::ID_W-1:0]          sample_1,
    input  logic [vmd_pkg::ID_W-1:0]          sample_2,
    input  logic [vmd_pkg::ID_W-1:0]          sample_3,
    input  logic [vmd_pkg::ID_W-1:0]          sample_4,
    input  logic [vmd_pkg::ID_W-1:0]          sample_5,
    input  logic [vmd_pkg::ID_W-1:0]          sample_6,
    input  logic [vmd_pkg::ID_W-1:0]          sample_7,

    // Output channel: one result per transfer.
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [vmd_pkg::ID_W-1:0]          chosen_material,
    output logic                              mostly_air
);

    vmd_pkg::cfg_t cfg_reg;

    logic [vmd_pkg::NUM_SAMPLES-1:0][vmd_pkg::ID_W-1:0] ids;

    logic            s1_ready;
    logic            s1_valid;
    vmd_pkg::cmp_t   s1_data;
    logic            s2_ready;
    logic            s2_valid;
    vmd_pkg::score_t s2_data;
    logic            s3_ready;

    // The configuration port never pushes back.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.air_id     <= 16'd0;
            cfg_reg.sand_id    <= 16'd1;
            cfg_reg.gravel_id  <= 16'd2;
            cfg_reg.water_id   <= 16'd3;
            cfg_reg.dirt_id    <= 16'd4;
            cfg_reg.stone_id   <= 16'd5;
            cfg_reg.top_weight <= 4'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (vmd_pkg::cfg_reg_t'(cfg_index))
                vmd_pkg::REG_AIR_ID:     cfg_reg.air_id     <= cfg_data;
                vmd_pkg::REG_SAND_ID:    cfg_reg.sand_id    <= cfg_data;
                vmd_pkg::REG_GRAVEL_ID:  cfg_reg.gravel_id  <= cfg_data;
                vmd_pkg::REG_WATER_ID:   cfg_reg.water_id   <= cfg_data;
                vmd_pkg::REG_DIRT_ID:    cfg_reg.dirt_id    <= cfg_data;
                vmd_pkg::REG_STONE_ID:   cfg_reg.stone_id   <= cfg_data;
                vmd_pkg::REG_TOP_WEIGHT:
                    cfg_reg.top_weight <= cfg_data[vmd_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample i sits at dx = i[0], dy = i[1], dz = i[2].
    assign ids[0] = sample_0;
    assign ids[1] = sample_1;
    assign ids[2] = sample_2;
    assign ids[3] = sample_3;
    assign ids[4] = sample_4;
    assign ids[5] = sample_5;
    assign ids[6] = sample_6;
    assign ids[7] = sample_7;

    // Stage one: equality matrix, air flags and priority codes.
    vmd_compare u_compare (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .valid_in  (in_valid),
        .ready_in  (s1_ready),
        .ids       (ids),
        .valid_out (s1_valid),
        .ready_out (s2_ready),
        .data_out  (s1_data)
    );

    // Stage two: weighted score and count per sample, air count per group.
    vmd_score u_score (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .valid_in  (s1_valid),
        .ready_in  (s2_ready),
        .data_in   (s1_data),
        .valid_out (s2_valid),
        .ready_out (s3_ready),
        .data_out  (s2_data)
    );

    // Stages three and four: max tree and output register.
    vmd_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .valid_in  (s2_valid),
        .ready_in  (s3_ready),
        .data_in   (s2_data),
        .valid_out (out_valid),
        .ready_out (!out_stall),
        .chosen    (chosen_material),
        .mostly    (mostly_air)
    );

    assign in_stall = !s1_ready;

    // The input side is only held when the first stage is occupied.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid)
        else $error("input held while stage one is empty");

    // An accepted group always lands in stage one.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid)
        else $error("accepted group did not enter stage one");

endmodule
